// ----- sv/chist_pkg.sv -----
// ----------------------------------------------------------------------------
// chist_pkg: shared widths and types for the clamped range histogram
// Sample, count and bin widths, and the request beat to the bin store.
// ----------------------------------------------------------------------------
package chist_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 24;
	localparam int BIN_BITS    = 8;
	localparam int BIN_COUNT   = 256;
	// dividend of the bin quotient: (sample - low) * 255
	localparam int NUM_BITS    = SAMPLE_BITS + BIN_BITS;
	// divider step counter holds 0 .. BIN_BITS
	localparam int STEP_BITS   = $clog2(BIN_BITS + 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COUNT_BITS-1:0]         count_t;
	typedef logic [BIN_BITS-1:0]           bin_t;

	// one request beat to the bin store
	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
		bin_t addr;
	} bins_req_t;

endpackage

// ----- sv/chist_div.sv -----
// ----------------------------------------------------------------------------
// chist_div: serial bin quotient divider
// Restoring division, one quotient bit per cycle, shifting the low dividend
// bits in behind a remainder that stays below the divisor.
// ----------------------------------------------------------------------------
module chist_div import chist_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [NUM_BITS-1:0]    num,
	input  logic [SAMPLE_BITS-1:0] den,
	output logic                   done,
	output bin_t                   quo
);

	logic [SAMPLE_BITS-1:0] rem_q;
	logic [SAMPLE_BITS-1:0] den_q;
	bin_t                   low_q;
	bin_t                   quo_q;
	logic [STEP_BITS-1:0]   cnt_q;
	logic                   done_q;

	logic [SAMPLE_BITS:0] trial;
	logic [SAMPLE_BITS:0] diff;
	logic                 fits;

	// shift the next dividend bit in and try the subtract
	assign trial = {rem_q, low_q[BIN_BITS-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= STEP_BITS'(BIN_BITS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == STEP_BITS'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			// the quotient stays below 256, so the high part is below den
			rem_q <= num[NUM_BITS-1:BIN_BITS];
			low_q <= num[BIN_BITS-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
			low_q <= {low_q[BIN_BITS-2:0], 1'b0};
			quo_q <= {quo_q[BIN_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- sv/chist_bins.sv -----
// ----------------------------------------------------------------------------
// chist_bins: bin count store
// 256 counts in one memory with a registered read port; a valid bit per bin
// lets a clear reset every bin at once, and an unwritten bin reads as zero.
// ----------------------------------------------------------------------------
module chist_bins import chist_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  bins_req_t req,
	input  count_t    wdata,
	output count_t    rdata
);

	count_t                 mem [BIN_COUNT];
	count_t                 rd_mem_q;
	logic [BIN_COUNT-1:0]   vld_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= wdata;
		end
		if (req.rd) begin
			rd_mem_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.wr) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.rd) begin
				rd_vld_q <= vld_q[req.addr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_mem_q : '0;

endmodule

// ----- sv/clamped_range_histogram.sv -----
// ----------------------------------------------------------------------------
// clamped_range_histogram: 256-bin histogram with running minimum and maximum
// Counts signed samples into bins over a configured range, reads one bin
// together with the extremes, and clears everything in one beat.
// ----------------------------------------------------------------------------
// Issue one command beat with start high while busy is low. A count beat
// (opcode 0) updates the extremes at once, then sorts the sample into a bin:
// above range_high goes to bin 255, below range_low to bin 0, otherwise the
// bin is floor((sample - range_low) * 255 / (range_high - range_low)); with
// range_high equal to range_low no bin is touched. Counts saturate at
// 2^24 - 1. A read beat (opcode 1) returns the count of bin_index with the
// current minimum and maximum; done is high for exactly one cycle, and the
// result fields are valid only in that cycle. The receiver has no way to
// stall, so capture the beat when done is seen. A clear beat (opcode 2) zeroes
// all bins and resets the extremes in the accept cycle itself; opcode 3 is
// dropped. A count inside the range goes through classify, dividend setup,
// the serial divider that forms one bin bit per cycle (8 steps), and a
// read-modify-write of the bin memory; a clamped count skips the divider,
// a count with an empty range ends after classify, a read passes the result
// state (done comes in the cycle after accept), and a clear leaves busy low.
// No clearing pass after reset: per-bin valid bits make every bin read as zero.
// Write range registers only while busy is low and no beat is pending.
// ----------------------------------------------------------------------------
module clamped_range_histogram import chist_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// command beat
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             opcode,
	input  sample_t                sample,
	input  bin_t                   bin_index,
	// result beat
	output logic                   done,
	output count_t                 bin_count,
	output sample_t                min_value,
	output sample_t                max_value,
	// range registers
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [SAMPLE_BITS-1:0] cfg_data
);

	localparam logic [1:0] OP_COUNT = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic REG_RANGE_LOW  = 1'b0;
	localparam logic REG_RANGE_HIGH = 1'b1;

	localparam sample_t SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam bin_t    BIN_TOP = '1;
	localparam count_t  CNT_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_LOAD,
		ST_DIV,
		ST_MEM_RD,
		ST_MEM_WR,
		ST_RSP
	} state_t;

	state_t                 state_q;
	sample_t                sample_q;
	logic [SAMPLE_BITS-1:0] d_q;
	bin_t                   bin_q;
	sample_t                min_q;
	sample_t                max_q;
	sample_t                low_q;
	sample_t                high_q;

	logic                   accept;
	logic [SAMPLE_BITS:0]   d_w;
	logic [SAMPLE_BITS:0]   den_w;
	logic [NUM_BITS-1:0]    num;
	logic                   div_load;
	logic                   div_done;
	bin_t                   div_quo;
	bins_req_t              bins_req;
	count_t                 bins_rdata;
	count_t                 bins_wdata;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_RSP);

	// range registers: plain writes; the one-bit index picks the low or high bound
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= sample_t'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_LOW:  low_q  <= cfg_data;
				REG_RANGE_HIGH: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// offset into the range and range width, one bit wider to stay exact
	assign d_w   = {sample_q[SAMPLE_BITS-1], sample_q} - {low_q[SAMPLE_BITS-1], low_q};
	assign den_w = {high_q[SAMPLE_BITS-1], high_q} - {low_q[SAMPLE_BITS-1], low_q};
	// times 255 as a shift and one subtract
	assign num   = {d_q, {BIN_BITS{1'b0}}} - {{BIN_BITS{1'b0}}, d_q};

	assign div_load = (state_q == ST_LOAD);

	chist_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (div_load),
		.num    (num),
		.den    (den_w[SAMPLE_BITS-1:0]),
		.done   (div_done),
		.quo    (div_quo)
	);

	// bin store requests: read on a read beat or ahead of an update,
	// write back the incremented count in the cycle after the read
	always_comb begin
		bins_req      = '0;
		bins_req.addr = bin_q;
		case (state_q)
			ST_IDLE: begin
				bins_req.rd   = accept && (opcode == OP_READ);
				bins_req.clr  = accept && (opcode == OP_CLEAR);
				bins_req.addr = bin_index;
			end
			ST_MEM_RD: bins_req.rd = 1'b1;
			ST_MEM_WR: bins_req.wr = 1'b1;
			default: ;
		endcase
	end

	// saturate: a full bin holds
	assign bins_wdata = (bins_rdata == CNT_MAX) ? bins_rdata : bins_rdata + 1'b1;

	chist_bins u_bins (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (bins_req),
		.wdata  (bins_wdata),
		.rdata  (bins_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sample_q <= '0;
			d_q      <= '0;
			bin_q    <= '0;
			min_q    <= SMAX;
			max_q    <= SMIN;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_COUNT: begin
								sample_q <= sample;
								// extremes track every counted sample
								if (sample < min_q) begin
									min_q <= sample;
								end
								if (sample > max_q) begin
									max_q <= sample;
								end
								state_q <= ST_CLASS;
							end
							OP_READ:  state_q <= ST_RSP;
							OP_CLEAR: begin
								min_q <= SMAX;
								max_q <= SMIN;
							end
							default: ;
						endcase
					end
				end
				ST_CLASS: begin
					d_q <= d_w[SAMPLE_BITS-1:0];
					// empty range: drop the sample; above wins over below
					if (high_q == low_q) begin
						state_q <= ST_IDLE;
					end else if (sample_q > high_q) begin
						bin_q   <= BIN_TOP;
						state_q <= ST_MEM_RD;
					end else if (sample_q < low_q) begin
						bin_q   <= '0;
						state_q <= ST_MEM_RD;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						bin_q   <= div_quo;
						state_q <= ST_MEM_RD;
					end
				end
				ST_MEM_RD: state_q <= ST_MEM_WR;
				ST_MEM_WR: state_q <= ST_IDLE;
				ST_RSP:    state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	assign bin_count = bins_rdata;
	assign min_value = min_q;
	assign max_value = max_q;

	// a quotient only arrives while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide wait");

	// a result beat always follows an accepted read command
	a_done_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept && (opcode == OP_READ)))
		else $error("result beat without a read command");

	// a clear resets both extremes in the next cycle
	a_clear_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (opcode == OP_CLEAR)) |=> (min_q == SMAX && max_q == SMIN))
		else $error("clear left the extremes set");

	// extremes cross only in the empty state
	a_extremes_order: assert property (@(posedge clk) disable iff (!arst_n)
		(min_q > max_q) |-> (min_q == SMAX && max_q == SMIN))
		else $error("minimum above maximum after a sample");

	// the bin store is written only at the end of an update
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		bins_req.wr |-> $past(state_q == ST_MEM_RD))
		else $error("bin write without a preceding read");

endmodule

// ----- sim/chist_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// chist_tb_pkg: command codes and register indexes for the histogram bench
// Shared by the stimulus top and the checker so that both name every code.
// ----------------------------------------------------------------------------
package chist_tb_pkg;

	typedef enum logic [1:0] {
		OP_COUNT  = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_UNUSED = 2'd3
	} op_e;

	localparam logic REG_RANGE_LOW  = 1'b0;
	localparam logic REG_RANGE_HIGH = 1'b1;

	localparam chist_pkg::sample_t SAMPLE_MIN =
		{1'b1, {(chist_pkg::SAMPLE_BITS-1){1'b0}}};
	localparam chist_pkg::sample_t SAMPLE_MAX =
		{1'b0, {(chist_pkg::SAMPLE_BITS-1){1'b1}}};

endpackage

// ----- sim/chist_checker.sv -----
// ----------------------------------------------------------------------------
// chist_checker: bin and extreme predictor for the clamped range histogram
// Watches command, result and register ports, keeps its own histogram, and
// compares every result beat against the oldest predicted read.
// ----------------------------------------------------------------------------
module chist_checker import chist_pkg::*; import chist_tb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic [1:0]             opcode,
	input  sample_t                sample,
	input  bin_t                   bin_index,
	input  logic                   done,
	input  count_t                 bin_count,
	input  sample_t                min_value,
	input  sample_t                max_value,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [SAMPLE_BITS-1:0] cfg_data,
	output int                     errors,
	output int                     pending
);

	typedef struct packed {
		count_t  tally;
		sample_t min_v;
		sample_t max_v;
	} read_result_t;

	count_t       hist_bins [BIN_COUNT];
	sample_t      seen_min;
	sample_t      seen_max;
	sample_t      bound_lo;
	sample_t      bound_hi;
	read_result_t pending_reads [$];
	int           miss_n;

	// Bin of a sample; the above-high test comes first for inverted ranges.
	function automatic bin_t sort_into_bin(sample_t s, sample_t lo, sample_t hi);
		longint num;
		longint den;
		if (s > hi)
			return bin_t'(BIN_COUNT - 1);
		if (s < lo)
			return '0;
		num = (longint'(s) - longint'(lo)) * (BIN_COUNT - 1);
		den = longint'(hi) - longint'(lo);
		return bin_t'(num / den);
	endfunction

	task automatic reset_hist();
		for (int i = 0; i < BIN_COUNT; i++)
			hist_bins[i] = '0;
		seen_min = SAMPLE_MAX;
		seen_max = SAMPLE_MIN;
	endtask

	task automatic tally_sample(sample_t s);
		bin_t b;
		if (s < seen_min)
			seen_min = s;
		if (s > seen_max)
			seen_max = s;
		// an empty range still moves the extremes but touches no bin
		if (bound_hi != bound_lo) begin
			b = sort_into_bin(s, bound_lo, bound_hi);
			if (hist_bins[b] != '1)
				hist_bins[b] = hist_bins[b] + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		read_result_t want;
		if (!arst_n) begin
			bound_lo = '0;
			bound_hi = sample_t'(1);
			reset_hist();
			pending_reads.delete();
			miss_n = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (pending_reads.size() == 0) begin
					miss_n++;
					if (miss_n <= 10)
						$display("[%0t] unexpected result: count %0d min %0d max %0d",
							$realtime, bin_count, min_value, max_value);
				end else begin
					want = pending_reads.pop_front();
					if (bin_count !== want.tally || min_value !== want.min_v ||
							max_value !== want.max_v) begin
						miss_n++;
						if (miss_n <= 10)
							$display("[%0t] read mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
								$realtime, want.tally, want.min_v, want.max_v,
								bin_count, min_value, max_value);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_RANGE_LOW)
					bound_lo = cfg_data;
				else
					bound_hi = cfg_data;
			end
			if (start && !busy) begin
				case (op_e'(opcode))
					OP_COUNT: tally_sample(sample);
					OP_READ: begin
						want.tally = hist_bins[bin_index];
						want.min_v = seen_min;
						want.max_v = seen_max;
						pending_reads.push_back(want);
					end
					OP_CLEAR: reset_hist();
					OP_UNUSED: ;
				endcase
			end
			errors <= miss_n;
			pending <= pending_reads.size();
		end
	end

endmodule

// ----- sim/tb_clamped_range_histogram.sv -----
// ----------------------------------------------------------------------------
// tb_clamped_range_histogram: stimulus and verdict for the range histogram
// Drives directed and random command beats over many range settings, with
// random idle gaps, and takes the failure count from the checker.
// ----------------------------------------------------------------------------
module tb_clamped_range_histogram;
	import chist_pkg::*;
	import chist_tb_pkg::*;

	localparam int PHASES    = 12;
	localparam int PER_PHASE = 92;
	// longest accept-to-accept span of the block, with some margin
	localparam int TAIL      = 20;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   start     = 1'b0;
	logic                   busy;
	logic [1:0]             opcode    = '0;
	sample_t                sample    = '0;
	bin_t                   bin_index = '0;
	logic                   done;
	count_t                 bin_count;
	sample_t                min_value;
	sample_t                max_value;
	logic                   cfg_we    = 1'b0;
	logic                   cfg_index = 1'b0;
	logic [SAMPLE_BITS-1:0] cfg_data  = '0;

	int errors;
	int pending;

	// range as last written, used only to aim the samples
	int   cur_lo;
	int   cur_hi;
	// a few bins per phase that samples and reads favor, so reads see counts
	bin_t hot [4];
	bit   steady;
	int   n_count, n_read, n_clear, n_unused, n_ranges;

	clamped_range_histogram dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.sample    (sample),
		.bin_index (bin_index),
		.done      (done),
		.bin_count (bin_count),
		.min_value (min_value),
		.max_value (max_value),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	chist_checker hist_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.sample    (sample),
		.bin_index (bin_index),
		.done      (done),
		.bin_count (bin_count),
		.min_value (min_value),
		.max_value (max_value),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// Present one command beat and hold it until the block takes it. Enter and
	// leave on a rising edge; start stays high on return so that a back-to-back
	// beat never lowers and raises it in one step.
	task automatic send(op_e op, sample_t s, bin_t b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		opcode    <= op;
		sample    <= s;
		bin_index <= b;
		// busy read right after the edge is its value before that edge
		@(posedge clk);
		while (busy)
			@(posedge clk);
		case (op)
			OP_COUNT:  n_count++;
			OP_READ:   n_read++;
			OP_CLEAR:  n_clear++;
			OP_UNUSED: n_unused++;
		endcase
	endtask

	// Drop start, wait for every predicted read to come back, then, for a nonzero
	// tail, let a count or clear with no result run out before the block is touched.
	task automatic settle(int tail);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		if (tail != 0) begin
			repeat (tail) @(posedge clk);
			while (busy)
				@(posedge clk);
		end
	endtask

	// Write both range registers; call only with the block idle.
	task automatic write_range(int lo, int hi);
		cur_lo    = lo;
		cur_hi    = hi;
		cfg_we    <= 1'b1;
		cfg_index <= REG_RANGE_LOW;
		cfg_data  <= lo[SAMPLE_BITS-1:0];
		@(posedge clk);
		cfg_index <= REG_RANGE_HIGH;
		cfg_data  <= hi[SAMPLE_BITS-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		n_ranges++;
	endtask

	// Pick the range for one random phase: extremes, narrow, one bin per
	// code, empty, inverted, and plain random bounds.
	task automatic pick_range(int k, output int lo, output int hi);
		int a;
		int b;
		a = int'(sample_t'($urandom));
		b = int'(sample_t'($urandom));
		case (k % 8)
			0: begin lo = int'(SAMPLE_MIN); hi = int'(SAMPLE_MAX); end
			1: begin lo = int'(SAMPLE_MAX); hi = int'(SAMPLE_MIN); end
			2: begin
				lo = int'($urandom_range(0, 65535 - 16)) - 32768;
				hi = lo + int'($urandom_range(1, 16));
			end
			3: begin
				lo = int'($urandom_range(0, 65535 - 255)) - 32768;
				hi = lo + BIN_COUNT - 1;
			end
			4: begin lo = a; hi = a; end
			6: begin lo = a; hi = b; end
			default: begin
				if (a == b)
					b = (a == int'(SAMPLE_MAX)) ? a - 1 : a + 1;
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
			end
		endcase
	endtask

	// Aim most samples into the range, a share at hot bins, the rest at the
	// extremes or anywhere in the field.
	function automatic sample_t pick_sample();
		int r;
		int span;
		int t;
		r    = $urandom_range(0, 9);
		span = cur_hi - cur_lo;
		if (r == 0)
			return SAMPLE_MIN;
		if (r == 1)
			return SAMPLE_MAX;
		if (r <= 7 && span > 0) begin
			if (r <= 4) begin
				t = hot[$urandom_range(0, 3)];
				return sample_t'(cur_lo + (t * span) / (BIN_COUNT - 1));
			end
			return sample_t'(cur_lo + int'($urandom_range(0, span)));
		end
		return sample_t'($urandom);
	endfunction

	initial begin
		int lo;
		int hi;
		int r;
		bin_t b;

		cur_lo = 0;
		cur_hi = 1;
		steady = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset range 0..1, read before any count (reset extremes
		// and empty bins), both field extremes, the range ends themselves,
		// an unused opcode, reads of both end bins, then a clear and a read.
		send(OP_READ, sample_t'(0), bin_t'(0));
		send(OP_COUNT, SAMPLE_MIN, bin_t'(0));
		send(OP_COUNT, SAMPLE_MAX, bin_t'(0));
		send(OP_COUNT, sample_t'(0), bin_t'(0));
		send(OP_COUNT, sample_t'(1), bin_t'(0));
		send(OP_UNUSED, sample_t'(16'h5a5a), bin_t'(8'ha5));
		send(OP_READ, sample_t'(0), bin_t'(0));
		send(OP_READ, sample_t'(0), bin_t'(255));
		send(OP_CLEAR, sample_t'(0), bin_t'(0));
		send(OP_READ, sample_t'(0), bin_t'(255));

		// Widest range: the divider sees its largest divisor.
		settle(TAIL);
		write_range(int'(SAMPLE_MIN), int'(SAMPLE_MAX));
		send(OP_COUNT, SAMPLE_MIN, bin_t'(0));
		send(OP_COUNT, SAMPLE_MAX, bin_t'(0));
		send(OP_COUNT, sample_t'(0), bin_t'(0));
		send(OP_READ, sample_t'(0), bin_t'(0));
		send(OP_READ, sample_t'(0), bin_t'(127));
		send(OP_READ, sample_t'(0), bin_t'(255));

		// Empty range: extremes move, no bin does.
		settle(TAIL);
		write_range(5, 5);
		send(OP_COUNT, sample_t'(5), bin_t'(0));
		send(OP_COUNT, sample_t'(-7), bin_t'(0));
		send(OP_READ, sample_t'(0), bin_t'(255));

		// Inverted range: every sample is clamped, the high test first.
		settle(TAIL);
		write_range(100, -100);
		send(OP_COUNT, sample_t'(0), bin_t'(0));
		send(OP_COUNT, sample_t'(-200), bin_t'(0));
		send(OP_COUNT, sample_t'(150), bin_t'(0));
		send(OP_COUNT, sample_t'(-100), bin_t'(0));
		send(OP_READ, sample_t'(0), bin_t'(0));
		send(OP_READ, sample_t'(0), bin_t'(255));

		// Random phases, each under a fresh range setting.
		for (int k = 0; k < PHASES; k++) begin
			settle(TAIL);
			pick_range(k, lo, hi);
			write_range(lo, hi);
			hot[0] = '0;
			hot[1] = bin_t'(BIN_COUNT - 1);
			hot[2] = bin_t'($urandom);
			hot[3] = bin_t'($urandom);
			for (int i = 0; i < PER_PHASE; i++) begin
				// switch at random between gappy stretches and back-to-back ones
				if (i % 30 == 0)
					steady = ($urandom_range(0, 2) == 0);
				// now and then hold off until every read has returned
				if ($urandom_range(0, 59) == 0)
					settle(0);
				r = $urandom_range(0, 99);
				b = ($urandom_range(0, 9) < 6) ? hot[$urandom_range(0, 3)]
					: bin_t'($urandom);
				if (r < 60)
					send(OP_COUNT, pick_sample(), bin_t'($urandom));
				else if (r < 92)
					send(OP_READ, sample_t'($urandom), b);
				else if (r < 96)
					send(OP_CLEAR, sample_t'($urandom), bin_t'($urandom));
				else
					send(OP_UNUSED, sample_t'($urandom), bin_t'($urandom));
			end
		end

		// Drain the last reads and give the block its longest span to finish.
		settle(TAIL);

		$display("Covered %0d beats: %0d counts, %0d reads, %0d clears, %0d unused.",
			n_count + n_read + n_clear + n_unused, n_count, n_read, n_clear, n_unused);
		$display("Range settings applied: %0d, incl. full, empty and inverted ranges.",
			n_ranges);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/chist_pkg.sv
sv/chist_div.sv
sv/chist_bins.sv
sv/clamped_range_histogram.sv
sim/chist_tb_pkg.sv
sim/chist_checker.sv
sim/tb_clamped_range_histogram.sv
